/* src/wlzba_pkg.sv */
// ----------------------------------------------------------------------------
// wlzba_pkg
// Shared types and constants of the zone block allocator.
// ----------------------------------------------------------------------------
package wlzba_pkg;

  localparam int NUM_BLOCKS_DEF  = 256;
  localparam int NUM_ZONES_DEF   = 16;
  localparam int BPZ_DEF         = 16;
  localparam int WEAR_LIMIT_DEF  = 1024;

  // page and block sizes are powers of two
  localparam int PAGE_BYTES  = 4096;
  localparam int BLOCK_BYTES = 262144;
  localparam int PAGE_SH     = $clog2(PAGE_BYTES);
  localparam int BLOCK_SH    = $clog2(BLOCK_BYTES);

  localparam int REQ_W   = 2;
  localparam int ZONE_W  = 4;
  localparam int OFF_W   = 22;
  localparam int CNT_W   = 23;
  localparam int STAT_W  = 2;
  localparam int LAT_W   = 26;
  localparam int EC_W    = 11;
  localparam int CFG_W   = 16;
  localparam int CFG_IW  = 1;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RESET  = 2'd1;

  localparam logic [CFG_IW-1:0] CFG_WRITE_LAT = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_ERASE_LAT = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_SPAN    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FIND_G,
    S_FIND_B,
    S_BLK,
    S_POP,
    S_RZB,
    S_RWEAR,
    S_RUPD,
    S_RPUSH,
    S_RFIND_G,
    S_RFIND_B,
    S_HSCAN,
    S_DONE
  } state_t;

endpackage

/* src/wlzba_if.sv */
// ----------------------------------------------------------------------------
// wlzba_in_if / wlzba_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface wlzba_in_if import wlzba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ZONE_W-1:0] zone_id;
  logic [OFF_W-1:0]  byte_offset;
  logic [CNT_W-1:0]  byte_count;

  modport source(output valid, req_type, zone_id, byte_offset, byte_count, input ready);
  modport sink(input valid, req_type, zone_id, byte_offset, byte_count, output ready);
endinterface

interface wlzba_out_if import wlzba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [LAT_W-1:0]  latency;
  logic [EC_W-1:0]   min_erase_count;
  logic [EC_W-1:0]   max_erase_count;
  logic [EC_W-1:0]   min_free_count;
  logic [EC_W-1:0]   zone_hint;

  modport source(output valid, status, latency, min_erase_count, max_erase_count,
                 min_free_count, zone_hint, input ready);
  modport sink(input valid, status, latency, min_erase_count, max_erase_count,
               min_free_count, zone_hint, output ready);
endinterface

/* src/wlzba_ram.sv */
// ----------------------------------------------------------------------------
// wlzba_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wlzba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/wear_leveling_zone_block_allocator.sv */
// ----------------------------------------------------------------------------
// wear_leveling_zone_block_allocator
// Flash block pool with per-count free stacks; appends take the least-worn
// free block, zone resets erase, count wear and refill the pool.
// ----------------------------------------------------------------------------
//  port      dir   kind            content
//  in_bus    in    valid/ready     req_type, zone_id, byte_offset, byte_count
//  out_bus   out   valid/ready     status, latency, erase counts, zone hint
//  cfg_*     in    write strobe    write_latency (0), erase_latency (1)
//
//  One request at a time. Append walks the blocks it allocates; reset walks every
//  zone block, plus a hint scan over all NUM_ZONES zones when the minimum
//  moves. Each block step follows the RAM read chain
//  bucket_top -> free_link/block_wear.
//  Reset needs no clearing pass; new requests are taken while a result waits.
// ----------------------------------------------------------------------------
module wear_leveling_zone_block_allocator import wlzba_pkg::*; #(
  parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
  parameter int NUM_ZONES       = NUM_ZONES_DEF,
  parameter int BLOCKS_PER_ZONE = BPZ_DEF,
  parameter int WEAR_LIMIT      = WEAR_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  wlzba_in_if.sink          in_bus,
  wlzba_out_if.source       out_bus,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int LNK_W  = $clog2(NUM_BLOCKS + 1);
  localparam int WW     = $clog2(WEAR_LIMIT + 2);
  localparam int BW     = $clog2(WEAR_LIMIT);
  localparam int NG     = (WEAR_LIMIT + 31) / 32;
  localparam int GW     = (NG > 1) ? $clog2(NG) : 1;
  localparam int BMI_W  = GW + 5;
  localparam int ZI_W   = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam int ZA_W   = $clog2(NUM_ZONES * BLOCKS_PER_ZONE);
  localparam int FILL_W = $clog2(BLOCKS_PER_ZONE + 1);
  localparam int LAST_W = CNT_W + 1 - BLOCK_SH;
  localparam int FST_W  = OFF_W - BLOCK_SH;
  localparam int PG_W   = CNT_W - PAGE_SH;
  localparam logic [LNK_W-1:0] NO_BLOCK = LNK_W'(NUM_BLOCKS);

  state_t state_r, state_nxt;

  // control state
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic              zok_r, zok_nxt;
  logic [ZI_W-1:0]   zi_r, zi_nxt;
  status_t           status_r, status_nxt;
  logic              empty_r, empty_nxt;
  logic              pend_r, pend_nxt;
  logic [FILL_W-1:0] i_r, i_nxt;
  logic [FILL_W-1:0] n_r, n_nxt;
  logic              rh_v_r, rh_v_nxt;
  logic [WW-1:0]     rh_val_r, rh_val_nxt;
  logic [ZI_W-1:0]   sidx_r, sidx_nxt;
  logic [CFG_W-1:0]  wlat_r, elat_r;
  logic [WW-1:0]     wear_low_r, wear_low_nxt;
  logic [WW-1:0]     wear_high_r, wear_high_nxt;
  logic              pool_e_r, pool_e_nxt;
  logic [WW-1:0]     pool_v_r, pool_v_nxt;
  logic [FILL_W-1:0] fill_r [NUM_ZONES];
  logic [FILL_W-1:0] fill_nxt [NUM_ZONES];
  logic              zmv_r [NUM_ZONES];
  logic              zmv_nxt [NUM_ZONES];
  logic [WW-1:0]     zmw_r [NUM_ZONES];
  logic [WW-1:0]     zmw_nxt [NUM_ZONES];
  logic [NUM_BLOCKS-1:0] vld_r, vld_nxt;
  logic [NG*32-1:0]  bm_r, bm_nxt;
  logic              ov_r, ov_nxt;
  logic              bt0_r;
  logic              rd0_r;

  // payload
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LAST_W-1:0] last_r, last_nxt;
  logic [LAT_W-1:0]  lat_r, lat_nxt;
  logic [GW-1:0]     grp_r, grp_nxt;
  logic [BW-1:0]     c_r, c_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic [BW-1:0]     ec1_r, ec1_nxt;
  logic [WW-1:0]     hmin_r, hmin_nxt;
  logic [STAT_W-1:0] o_status_r, o_status_nxt;
  logic [LAT_W-1:0]  o_lat_r, o_lat_nxt;
  logic [EC_W-1:0]   o_min_r, o_min_nxt;
  logic [EC_W-1:0]   o_max_r, o_max_nxt;
  logic [EC_W-1:0]   o_pool_r, o_pool_nxt;
  logic [EC_W-1:0]   o_hint_r, o_hint_nxt;

  // memory ports
  logic              bw_we;
  logic [BLK_W-1:0]  bw_raddr;
  logic [WW-1:0]     bw_q;
  logic              fl_we;
  logic [LNK_W-1:0]  fl_wdata;
  logic [LNK_W-1:0]  fl_q;
  logic              bt_we;
  logic [BW-1:0]     bt_waddr, bt_raddr;
  logic [BLK_W-1:0]  bt_wdata, bt_q;
  logic [BLK_W-1:0]  bt_top;
  logic              zb_we;
  logic [BLK_W-1:0]  zb_q;

  // helpers
  logic [GW-1:0]     grp_sel;
  logic              any_nz;
  logic [31:0]       grp_bits;
  logic [4:0]        bit_sel;
  logic [BW-1:0]     c_find;
  logic [ZA_W-1:0]   zbase;
  logic [FILL_W-1:0] fill_cur;
  logic [LAST_W-1:0] last_c;
  logic [FST_W-1:0]  first_c;
  logic [CNT_W:0]    span_end;
  logic [WW-1:0]     ec_cur, ec_p1;
  logic              do_push;
  logic [LNK_W-1:0]  link;
  logic              scan_need;
  logic [ZI_W-1:0]   zmw_ra;
  logic [WW-1:0]     hmin_f;
  logic [PG_W-1:0]   pages;

  wlzba_ram #(.WIDTH(WW), .DEPTH(NUM_BLOCKS)) u_wear (
    .clk(clk), .we(bw_we), .waddr(blk_r), .wdata(ec_p1), .raddr(bw_raddr), .rdata(bw_q)
  );
  wlzba_ram #(.WIDTH(LNK_W), .DEPTH(NUM_BLOCKS)) u_link (
    .clk(clk), .we(fl_we), .waddr(blk_r), .wdata(fl_wdata), .raddr(bt_top), .rdata(fl_q)
  );
  wlzba_ram #(.WIDTH(BLK_W), .DEPTH(WEAR_LIMIT)) u_top (
    .clk(clk), .we(bt_we), .waddr(bt_waddr), .wdata(bt_wdata), .raddr(bt_raddr),
    .rdata(bt_q)
  );
  wlzba_ram #(.WIDTH(BLK_W), .DEPTH(NUM_ZONES * BLOCKS_PER_ZONE)) u_zone (
    .clk(clk), .we(zb_we), .waddr(zbase + ZA_W'(fill_cur)), .wdata(blk_r),
    .raddr(zbase + ZA_W'(i_r)), .rdata(zb_q)
  );

  // bucket zero starts out topped by the last block until its first pop
  assign bt_top = (rd0_r && !bt0_r) ? BLK_W'(NUM_BLOCKS - 1) : bt_q;

  // lowest nonempty bucket, group first, then bit within group
  always_comb begin
    grp_sel = '0;
    any_nz  = 1'b0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (|bm_r[g*32 +: 32]) begin
        grp_sel = GW'(g);
        any_nz  = 1'b1;
      end
    end
  end

  always_comb begin
    grp_bits = bm_r[{grp_r, 5'd0} +: 32];
    bit_sel  = '0;
    for (int b = 31; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = 5'(b);
      end
    end
  end

  assign c_find   = BW'({grp_r, bit_sel});
  assign zbase    = ZA_W'(32'(zi_r) * BLOCKS_PER_ZONE);
  assign fill_cur = fill_r[zi_r];
  assign span_end = (CNT_W+1)'(off_r) + (CNT_W+1)'(cnt_r) - (CNT_W+1)'(1);
  assign last_c   = LAST_W'(span_end >> BLOCK_SH);
  assign first_c  = off_r[OFF_W-1:BLOCK_SH];
  assign pages    = cnt_r[CNT_W-1:PAGE_SH];
  assign ec_cur   = vld_r[blk_r] ? bw_q : '0;
  assign ec_p1    = ec_cur + WW'(1);
  assign do_push  = 32'(ec_p1) < WEAR_LIMIT;
  // untouched blocks still follow the reset chain: each links to the one below
  assign link     = vld_r[blk_r] ? fl_q :
                    ((blk_r == '0) ? NO_BLOCK : LNK_W'(blk_r) - LNK_W'(1));
  assign scan_need = rh_v_r && (rh_val_r == wear_low_r) &&
                     (empty_r || (WW'(c_find) != wear_low_r));
  assign zmw_ra   = (state_r == S_HSCAN) ? sidx_r : zi_r;
  assign hmin_f   = (zmv_r[zmw_ra] && (zmw_r[zmw_ra] < hmin_r)) ? zmw_r[zmw_ra] : hmin_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!zok_r || ((req_r != REQ_APPEND) && (req_r != REQ_RESET))) begin
          state_nxt = S_DONE;
        end else if (req_r == REQ_APPEND) begin
          if ((cnt_r == '0) || (32'(last_c) >= BLOCKS_PER_ZONE)) state_nxt = S_DONE;
          else state_nxt = S_FIND_G;
        end else if (fill_cur == '0) begin
          state_nxt = S_RFIND_G;
        end else begin
          state_nxt = S_RZB;
        end
      end
      S_FIND_G:  state_nxt = S_FIND_B;
      S_FIND_B: begin
        if ((32'(i_r) > 32'(last_r)) || empty_r) state_nxt = S_DONE;
        else state_nxt = S_BLK;
      end
      S_BLK:     state_nxt = S_POP;
      S_POP:     state_nxt = S_FIND_G;
      S_RZB:     state_nxt = S_RWEAR;
      S_RWEAR:   state_nxt = S_RUPD;
      S_RUPD: begin
        if (do_push) state_nxt = S_RPUSH;
        else if (i_r + FILL_W'(1) < n_r) state_nxt = S_RZB;
        else state_nxt = S_RFIND_G;
      end
      S_RPUSH: begin
        if (i_r + FILL_W'(1) < n_r) state_nxt = S_RZB;
        else state_nxt = S_RFIND_G;
      end
      S_RFIND_G: state_nxt = S_RFIND_B;
      S_RFIND_B: begin
        if (scan_need) state_nxt = S_HSCAN;
        else state_nxt = S_DONE;
      end
      S_HSCAN: begin
        if (sidx_r == ZI_W'(NUM_ZONES - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_bus.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt       = req_r;
    zok_nxt       = zok_r;
    zi_nxt        = zi_r;
    status_nxt    = status_r;
    empty_nxt     = empty_r;
    pend_nxt      = pend_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    rh_v_nxt      = rh_v_r;
    rh_val_nxt    = rh_val_r;
    sidx_nxt      = sidx_r;
    wear_low_nxt  = wear_low_r;
    wear_high_nxt = wear_high_r;
    pool_e_nxt    = pool_e_r;
    pool_v_nxt    = pool_v_r;
    fill_nxt      = fill_r;
    zmv_nxt       = zmv_r;
    zmw_nxt       = zmw_r;
    vld_nxt       = vld_r;
    bm_nxt        = bm_r;
    ov_nxt        = ov_r;
    off_nxt       = off_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    lat_nxt       = lat_r;
    grp_nxt       = grp_r;
    c_nxt         = c_r;
    blk_nxt       = blk_r;
    ec1_nxt       = ec1_r;
    hmin_nxt      = hmin_r;
    o_status_nxt  = o_status_r;
    o_lat_nxt     = o_lat_r;
    o_min_nxt     = o_min_r;
    o_max_nxt     = o_max_r;
    o_pool_nxt    = o_pool_r;
    o_hint_nxt    = o_hint_r;
    bw_we         = 1'b0;
    bw_raddr      = bt_top;
    fl_we         = 1'b0;
    fl_wdata      = bm_r[BMI_W'(ec1_r)] ? LNK_W'(bt_top) : NO_BLOCK;
    bt_we         = 1'b0;
    bt_waddr      = c_r;
    bt_wdata      = blk_r;
    bt_raddr      = c_find;
    zb_we         = 1'b0;

    if (ov_r && out_bus.ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          req_nxt = in_bus.req_type;
          zok_nxt = 32'(in_bus.zone_id) < NUM_ZONES;
          zi_nxt  = ZI_W'(in_bus.zone_id);
          off_nxt = in_bus.byte_offset;
          cnt_nxt = in_bus.byte_count;
        end
      end
      S_CHECK: begin
        status_nxt = ST_OK;
        lat_nxt    = '0;
        pend_nxt   = 1'b0;
        last_nxt   = last_c;
        if (zok_r && (req_r == REQ_APPEND) && (cnt_r != '0)) begin
          if (32'(last_c) >= BLOCKS_PER_ZONE) status_nxt = ST_SPAN;
          else lat_nxt = LAT_W'(32'(pages) * 32'(wlat_r));
          // block walk starts at the later of the first spanned block and the fill
          i_nxt = (32'(first_c) > 32'(fill_cur)) ? FILL_W'(first_c) : fill_cur;
        end
        if (zok_r && (req_r == REQ_RESET)) begin
          rh_v_nxt       = zmv_r[zi_r];
          rh_val_nxt     = zmw_r[zi_r];
          zmv_nxt[zi_r]  = 1'b0;
          n_nxt          = fill_cur;
          fill_nxt[zi_r] = '0;
          i_nxt          = '0;
        end
      end
      S_FIND_G, S_RFIND_G: begin
        grp_nxt   = grp_sel;
        empty_nxt = !any_nz;
      end
      S_FIND_B: begin
        if (pend_r) begin
          pool_e_nxt = empty_r;
          pool_v_nxt = WW'(c_find);
        end
        c_nxt = c_find;
        if ((32'(i_r) <= 32'(last_r)) && empty_r) begin
          status_nxt = ST_NO_FREE;
          lat_nxt    = '0;
        end
      end
      S_BLK: begin
        blk_nxt = bt_top;
      end
      S_POP: begin
        if (link == NO_BLOCK) begin
          bm_nxt[BMI_W'(c_r)] = 1'b0;
        end else begin
          bt_we    = 1'b1;
          bt_wdata = link[BLK_W-1:0];
        end
        if (!zmv_r[zi_r] || (ec_cur < zmw_r[zi_r])) begin
          zmv_nxt[zi_r] = 1'b1;
          zmw_nxt[zi_r] = ec_cur;
        end
        zb_we          = 1'b1;
        fill_nxt[zi_r] = fill_cur + FILL_W'(1);
        i_nxt          = i_r + FILL_W'(1);
        pend_nxt       = 1'b1;
      end
      S_RWEAR: begin
        blk_nxt  = zb_q;
        bw_raddr = zb_q;
      end
      S_RUPD: begin
        bw_we          = 1'b1;
        vld_nxt[blk_r] = 1'b1;
        lat_nxt        = lat_r + LAT_W'(elat_r);
        if (ec_cur == wear_high_r) wear_high_nxt = wear_high_r + WW'(1);
        bt_raddr = BW'(ec_p1);
        ec1_nxt  = BW'(ec_p1);
        if (!do_push) i_nxt = i_r + FILL_W'(1);
      end
      S_RPUSH: begin
        fl_we    = 1'b1;
        bt_we    = 1'b1;
        bt_waddr = ec1_r;
        bm_nxt[BMI_W'(ec1_r)] = 1'b1;
        i_nxt    = i_r + FILL_W'(1);
      end
      S_RFIND_B: begin
        pool_e_nxt = empty_r;
        pool_v_nxt = WW'(c_find);
        hmin_nxt   = WW'(WEAR_LIMIT + 1);
        sidx_nxt   = '0;
      end
      S_HSCAN: begin
        hmin_nxt = hmin_f;
        sidx_nxt = sidx_r + ZI_W'(1);
        if (sidx_r == ZI_W'(NUM_ZONES - 1)) begin
          if (pool_e_r || (hmin_f < pool_v_r)) wear_low_nxt = hmin_f;
          else wear_low_nxt = pool_v_r;
        end
      end
      S_DONE: begin
        if (!ov_r || out_bus.ready) begin
          ov_nxt       = 1'b1;
          o_status_nxt = status_r;
          o_lat_nxt    = lat_r;
          o_min_nxt    = EC_W'(wear_low_r);
          o_max_nxt    = EC_W'(wear_high_r);
          o_pool_nxt   = pool_e_r ? '1 : EC_W'(pool_v_r);
          o_hint_nxt   = (zok_r && zmv_r[zi_r]) ? EC_W'(zmw_r[zi_r]) : '1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r       <= '0;
      zok_r       <= 1'b0;
      zi_r        <= '0;
      status_r    <= ST_OK;
      empty_r     <= 1'b0;
      pend_r      <= 1'b0;
      i_r         <= '0;
      n_r         <= '0;
      rh_v_r      <= 1'b0;
      rh_val_r    <= '0;
      sidx_r      <= '0;
      wlat_r      <= CFG_W'(1);
      elat_r      <= CFG_W'(1);
      wear_low_r  <= '0;
      wear_high_r <= '0;
      pool_e_r    <= 1'b0;
      pool_v_r    <= '0;
      for (int z = 0; z < NUM_ZONES; z++) begin
        fill_r[z] <= '0;
        zmv_r[z]  <= 1'b0;
        zmw_r[z]  <= '0;
      end
      vld_r <= '0;
      bm_r  <= (NG*32)'(1);
      ov_r  <= 1'b0;
      bt0_r <= 1'b0;
      rd0_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_r       <= req_nxt;
      zok_r       <= zok_nxt;
      zi_r        <= zi_nxt;
      status_r    <= status_nxt;
      empty_r     <= empty_nxt;
      pend_r      <= pend_nxt;
      i_r         <= i_nxt;
      n_r         <= n_nxt;
      rh_v_r      <= rh_v_nxt;
      rh_val_r    <= rh_val_nxt;
      sidx_r      <= sidx_nxt;
      wear_low_r  <= wear_low_nxt;
      wear_high_r <= wear_high_nxt;
      pool_e_r    <= pool_e_nxt;
      pool_v_r    <= pool_v_nxt;
      fill_r      <= fill_nxt;
      zmv_r       <= zmv_nxt;
      zmw_r       <= zmw_nxt;
      vld_r       <= vld_nxt;
      bm_r        <= bm_nxt;
      ov_r        <= ov_nxt;
      bt0_r       <= bt0_r | (bt_we && (bt_waddr == '0));
      rd0_r       <= (bt_raddr == '0);
      if (cfg_we) begin
        case (cfg_index)
          CFG_WRITE_LAT: wlat_r <= cfg_wdata;
          CFG_ERASE_LAT: elat_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    lat_r      <= lat_nxt;
    grp_r      <= grp_nxt;
    c_r        <= c_nxt;
    blk_r      <= blk_nxt;
    ec1_r      <= ec1_nxt;
    hmin_r     <= hmin_nxt;
    o_status_r <= o_status_nxt;
    o_lat_r    <= o_lat_nxt;
    o_min_r    <= o_min_nxt;
    o_max_r    <= o_max_nxt;
    o_pool_r   <= o_pool_nxt;
    o_hint_r   <= o_hint_nxt;
  end

  assign in_bus.ready            = (state_r == S_IDLE);
  assign out_bus.valid           = ov_r;
  assign out_bus.status          = o_status_r;
  assign out_bus.latency         = o_lat_r;
  assign out_bus.min_erase_count = o_min_r;
  assign out_bus.max_erase_count = o_max_r;
  assign out_bus.min_free_count  = o_pool_r;
  assign out_bus.zone_hint       = o_hint_r;

endmodule
